[rtl/cbm_pkg.sv]
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

    // default store geometry
    localparam int DEF_STORE_BANKS    = 16;
    localparam int DEF_RAM_BANK_BYTES = 8192;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    // control window layout, offsets from the start of the control window
    localparam logic [31:0] CTRL_SPAN    = 32'h6000;
    localparam logic [15:0] CTRL_ROM_LO  = 16'h2000;
    localparam logic [15:0] CTRL_ROM_HI  = 16'h3000;
    localparam logic [15:0] CTRL_RAM_SEL = 16'h4000;
    localparam logic [3:0]  RAM_EN_KEY   = 4'hA;

    localparam logic [24:0] OFFSET_LIMIT = 25'h80_0000;
    localparam logic [7:0]  FILL_BYTE    = 8'hFF;
    localparam logic [8:0]  ROM_BANK_RST = 9'd1;

    // configuration register indexes
    localparam logic [2:0] CFG_CTL_FIRST        = 3'd0;
    localparam logic [2:0] CFG_ROM_WINDOW_FIRST = 3'd1;
    localparam logic [2:0] CFG_ROM_BANK_LEN     = 3'd2;
    localparam logic [2:0] CFG_ROM_IMAGE_SIZE   = 3'd3;
    localparam logic [2:0] CFG_RAM_WINDOW_FIRST = 3'd4;
    localparam logic [2:0] CFG_RAM_BANK_LEN     = 3'd5;
    localparam logic [2:0] CFG_RAM_BANK_COUNT   = 3'd6;

    typedef enum logic [1:0] {
        CMD_ROM_RD  = 2'd0,
        CMD_CTRL_WR = 2'd1,
        CMD_RAM_RD  = 2'd2,
        CMD_RAM_WR  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] bus_address;
        logic [7:0]  write_byte;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [7:0]  read_byte;
        logic        rom_fetch;
        logic [22:0] rom_offset;
    } t_rsp;

    typedef struct packed {
        logic [31:0] ctl_first;
        logic [31:0] rom_window_first;
        logic [14:0] rom_bank_len;
        logic [23:0] rom_image_size;
        logic [31:0] ram_window_first;
        logic [13:0] ram_bank_len;
        logic [4:0]  ram_bank_count;
    } t_cfg;

    // request class decided by the front
    typedef enum logic [3:0] {
        K_ROM_FIX,
        K_ROM_BANK,
        K_ROM_BAD,
        K_CTL_EN,
        K_CTL_BLO,
        K_CTL_BHI,
        K_CTL_RAMB,
        K_CTL_BAD,
        K_RAM_RD,
        K_RAM_WR,
        K_RD_BAD,
        K_WR_BAD
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] rel;
        logic [7:0]  wbyte;
    } t_job;

endpackage

[rtl/cartridge_bank_mapper_top.sv]
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_top
// Banked ROM and RAM mapper: configuration registers, request front,
// queue and execution back.
// ----------------------------------------------------------------------------
// the back sequencer takes each request through pop, bank multiply and execute
// steps, with a store read step after execute for a RAM read, and pops no new
// request until the result is registered; a result not yet taken stalls it
// reset: synchronous; registers and bank state return to reset values, then
// a clearing pass over all STORE_BANKS * RAM_BANK_BYTES bytes (131072 by default)
// zeroes the RAM store while no request is taken
module cartridge_bank_mapper_top
    import cbm_pkg::*;
#(
    parameter int STORE_BANKS    = DEF_STORE_BANKS,
    parameter int RAM_BANK_BYTES = DEF_RAM_BANK_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_rsp,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_cfg r_cfg;
    t_job w_push_job;
    t_job w_head_job;
    logic w_push;
    logic w_pop;
    logic w_q_full;
    logic w_q_empty;
    logic w_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ctl_first        <= 32'd0;
            r_cfg.rom_window_first <= 32'd0;
            r_cfg.rom_bank_len     <= 15'd16384;
            r_cfg.rom_image_size   <= 24'd32768;
            r_cfg.ram_window_first <= 32'd40960;
            r_cfg.ram_bank_len     <= 14'd8192;
            r_cfg.ram_bank_count   <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CTL_FIRST:        r_cfg.ctl_first        <= i_cfg_data;
                CFG_ROM_WINDOW_FIRST: r_cfg.rom_window_first <= i_cfg_data;
                CFG_ROM_BANK_LEN:     r_cfg.rom_bank_len     <= i_cfg_data[14:0];
                CFG_ROM_IMAGE_SIZE:   r_cfg.rom_image_size   <= i_cfg_data[23:0];
                CFG_RAM_WINDOW_FIRST: r_cfg.ram_window_first <= i_cfg_data;
                CFG_RAM_BANK_LEN:     r_cfg.ram_bank_len     <= i_cfg_data[13:0];
                CFG_RAM_BANK_COUNT:   r_cfg.ram_bank_count   <= i_cfg_data[4:0];
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    cbm_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .i_cfg      (r_cfg),
        .i_q_full   (w_q_full),
        .i_clearing (w_clearing),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    cbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    cbm_back #(
        .STORE_BANKS    (STORE_BANKS),
        .RAM_BANK_BYTES (RAM_BANK_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (w_q_empty),
        .i_q_job     (w_head_job),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

[rtl/cbm_front.sv]
// ----------------------------------------------------------------------------
// cbm_front
// Accepts requests and classifies them against the configured windows.
// ----------------------------------------------------------------------------
module cbm_front
    import cbm_pkg::*;
(
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_req,
    input  t_cfg i_cfg,
    input  logic i_q_full,
    input  logic i_clearing,
    output logic o_push,
    output t_job o_job
);

    logic [32:0] w_rom_rel;
    logic [32:0] w_ctl_rel;
    logic [32:0] w_ram_rel;
    logic [15:0] w_rom_span;
    logic [15:0] w_rom_hi_rel;
    logic        w_rom_in;
    logic        w_rom_hi;
    logic        w_ctl_in;
    logic        w_ram_in;

    assign w_rom_rel = {1'b0, i_in_req.bus_address} - {1'b0, i_cfg.rom_window_first};
    assign w_ctl_rel = {1'b0, i_in_req.bus_address} - {1'b0, i_cfg.ctl_first};
    assign w_ram_rel = {1'b0, i_in_req.bus_address} - {1'b0, i_cfg.ram_window_first};

    // top bit set means the address lies below the window
    assign w_rom_span   = {i_cfg.rom_bank_len, 1'b0};
    assign w_rom_in     = !w_rom_rel[32] && (w_rom_rel[31:0] < {16'b0, w_rom_span});
    assign w_rom_hi     = w_rom_rel[15:0] >= {1'b0, i_cfg.rom_bank_len};
    assign w_rom_hi_rel = w_rom_rel[15:0] - {1'b0, i_cfg.rom_bank_len};
    assign w_ctl_in     = !w_ctl_rel[32] && (w_ctl_rel[31:0] < CTRL_SPAN);
    assign w_ram_in     = !w_ram_rel[32] && (w_ram_rel[31:0] < {18'b0, i_cfg.ram_bank_len});

    assign o_in_ready = !i_q_full && !i_clearing;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        o_job.wbyte = i_in_req.write_byte;
        o_job.rel   = 16'b0;
        o_job.kind  = K_CTL_BAD;
        case (i_in_req.cmd)
            CMD_ROM_RD: begin
                if (!w_rom_in) begin
                    o_job.kind = K_ROM_BAD;
                end else if (w_rom_hi) begin
                    o_job.kind = K_ROM_BANK;
                    o_job.rel  = w_rom_hi_rel;
                end else begin
                    o_job.kind = K_ROM_FIX;
                    o_job.rel  = w_rom_rel[15:0];
                end
            end
            CMD_CTRL_WR: begin
                if (!w_ctl_in) begin
                    o_job.kind = K_CTL_BAD;
                end else if (w_ctl_rel[15:0] < CTRL_ROM_LO) begin
                    o_job.kind = K_CTL_EN;
                end else if (w_ctl_rel[15:0] < CTRL_ROM_HI) begin
                    o_job.kind = K_CTL_BLO;
                end else if (w_ctl_rel[15:0] < CTRL_RAM_SEL) begin
                    o_job.kind = K_CTL_BHI;
                end else begin
                    o_job.kind = K_CTL_RAMB;
                end
            end
            CMD_RAM_RD: begin
                o_job.kind = w_ram_in ? K_RAM_RD : K_RD_BAD;
                o_job.rel  = w_ram_rel[15:0];
            end
            CMD_RAM_WR: begin
                o_job.kind = w_ram_in ? K_RAM_WR : K_WR_BAD;
                o_job.rel  = w_ram_rel[15:0];
            end
            default: begin
                o_job.kind = K_CTL_BAD;
            end
        endcase
    end

endmodule

[rtl/cbm_queue.sv]
// ----------------------------------------------------------------------------
// cbm_queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module cbm_queue
    import cbm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_job          r_slot [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = r_count == CW'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/cbm_back.sv]
// ----------------------------------------------------------------------------
// cbm_back
// Carries out classified requests: bank registers, banked RAM store and
// the result register.
// ----------------------------------------------------------------------------
module cbm_back
    import cbm_pkg::*;
#(
    parameter int STORE_BANKS    = DEF_STORE_BANKS,
    parameter int RAM_BANK_BYTES = DEF_RAM_BANK_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_q_empty,
    input  t_job i_q_job,
    output logic o_pop,
    output logic o_clearing,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_rsp
);

    localparam int STORE_DEPTH = STORE_BANKS * RAM_BANK_BYTES;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [31:0] STORE_LIMIT = 32'(STORE_DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_EXE,
        S_RD
    } t_state;

    t_state      r_state;
    t_job        r_job;
    logic [8:0]  r_rom_bank;
    logic [3:0]  r_ram_bank;
    logic        r_ram_en;
    logic [23:0] r_rom_prod;
    logic [17:0] r_ram_prod;
    logic [18:0] r_ram_lim;
    logic        r_rd_hit;
    logic [AW-1:0] r_clr_addr;
    logic        r_out_valid;
    t_rsp        r_out;
    logic [7:0]  r_mem_q;
    logic [7:0]  r_mem [STORE_DEPTH];

    logic [4:0]  w_banks;
    logic [24:0] w_rom_off;
    logic        w_rom_ok;
    logic [18:0] w_ram_off;
    logic [31:0] w_ram_off32;
    logic        w_ram_ok;
    logic [AW-1:0] w_idx;
    logic        w_out_free;
    logic        w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    logic [7:0]  w_mem_wdata;
    logic        w_mem_re;
    t_rsp        w_rsp;

    assign o_clearing  = r_state == S_CLEAR;
    assign o_pop       = (r_state == S_IDLE) && !i_q_empty;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign w_banks = (i_cfg.ram_bank_count > 5'(STORE_BANKS)) ? 5'(STORE_BANKS)
                                                              : i_cfg.ram_bank_count;

    assign w_rom_off = (r_job.kind == K_ROM_BANK) ? {1'b0, r_rom_prod} + 25'(r_job.rel)
                                                  : 25'(r_job.rel);
    assign w_rom_ok  = (w_rom_off < {1'b0, i_cfg.rom_image_size}) && (w_rom_off < OFFSET_LIMIT);

    assign w_ram_off   = {1'b0, r_ram_prod} + 19'(r_job.rel[13:0]);
    assign w_ram_off32 = 32'(w_ram_off);
    assign w_ram_ok    = (w_ram_off < r_ram_lim) && (w_ram_off32 < STORE_LIMIT);
    assign w_idx       = w_ram_off32[AW-1:0];

    assign w_mem_re    = (r_state == S_EXE) && (r_job.kind == K_RAM_RD);
    assign w_mem_we    = o_clearing || ((r_state == S_EXE) && (r_job.kind == K_RAM_WR)
                                        && r_ram_en && w_ram_ok && w_out_free);
    assign w_mem_waddr = o_clearing ? r_clr_addr : w_idx;
    assign w_mem_wdata = o_clearing ? 8'h00 : r_job.wbyte;

    // result of every request that does not read the store
    always_comb begin
        w_rsp = '0;
        case (r_job.kind)
            K_ROM_FIX, K_ROM_BANK: begin
                if (w_rom_ok) begin
                    w_rsp.rom_fetch  = 1'b1;
                    w_rsp.rom_offset = w_rom_off[22:0];
                end else begin
                    w_rsp.read_byte = FILL_BYTE;
                end
            end
            K_ROM_BAD, K_RD_BAD: begin
                w_rsp.status    = 1'b1;
                w_rsp.read_byte = FILL_BYTE;
            end
            K_CTL_BAD, K_WR_BAD: begin
                w_rsp.status = 1'b1;
            end
            default: begin
                w_rsp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_mem_q <= r_mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_rom_bank  <= ROM_BANK_RST;
            r_ram_bank  <= '0;
            r_ram_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(STORE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_job   <= i_q_job;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rom_prod <= 24'(r_rom_bank) * 24'(i_cfg.rom_bank_len);
                    r_ram_prod <= 18'(r_ram_bank) * 18'(i_cfg.ram_bank_len);
                    r_ram_lim  <= 19'(w_banks) * 19'(i_cfg.ram_bank_len);
                    r_state    <= S_EXE;
                end
                S_EXE: begin
                    if (r_job.kind == K_RAM_RD) begin
                        r_rd_hit <= r_ram_en && w_ram_ok;
                        r_state  <= S_RD;
                    end else if (w_out_free) begin
                        r_out       <= w_rsp;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        case (r_job.kind)
                            K_CTL_EN:   r_ram_en <= r_job.wbyte[3:0] == RAM_EN_KEY;
                            K_CTL_BLO:  r_rom_bank[7:0] <= r_job.wbyte;
                            K_CTL_BHI:  r_rom_bank[8] <= r_job.wbyte[0];
                            K_CTL_RAMB: r_ram_bank <= r_job.wbyte[3:0];
                            default:    r_ram_en <= r_ram_en;
                        endcase
                    end
                end
                S_RD: begin
                    if (w_out_free) begin
                        r_out.status     <= 1'b0;
                        r_out.read_byte  <= r_rd_hit ? r_mem_q : FILL_BYTE;
                        r_out.rom_fetch  <= 1'b0;
                        r_out.rom_offset <= '0;
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[tb/tb_cartridge_bank_mapper_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cartridge_bank_mapper_top
// Drives bus requests into the cartridge bank mapper and checks every result
// against a typed table result or an in-bench model of the bank registers and
// banked RAM. A short table of hand-picked requests runs first, then random
// traffic under eight register settings, request and result sides idling in turn.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper_top;
    import cbm_pkg::*;

    localparam int          STALL_LIMIT     = 500000;
    localparam int          DRAIN_CYCLES    = 10;
    localparam int          DIRECTED_ROWS   = 25;
    localparam int          PHASES          = 8;
    localparam int          ITEMS_PER_PHASE = 250;
    localparam int          RAM_BYTES       = 16 * 8192;
    localparam logic [63:0] CTRL_WINDOW     = 64'h6000;
    localparam logic [63:0] EN_LIMIT        = 64'h2000;
    localparam logic [63:0] LOW_LIMIT       = 64'h3000;
    localparam logic [63:0] HIGH_LIMIT      = 64'h4000;
    localparam logic [63:0] OFFSET_CAP      = 64'h80_0000;
    localparam logic [7:0]  FF_BYTE         = 8'hFF;
    localparam logic [3:0]  ENABLE_KEY      = 4'hA;
    localparam logic        TYPED           = 1'b1;
    localparam logic        PREDICTED       = 1'b0;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        t_req req;
        logic typed_exp;
        t_rsp rsp;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_req        i_in_req;
    logic        o_out_valid;
    logic        i_out_ready;
    t_rsp        o_out_rsp;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    // model of the mapper state
    t_cfg        cfg_shadow;
    logic [8:0]  rom_bank_sel;
    logic [3:0]  ram_bank_sel;
    logic        ram_on;
    logic [7:0]  cart_ram [0:RAM_BYTES-1];

    t_rsp        due_responses [$];
    int unsigned mismatch_count;
    int unsigned results_seen;
    int unsigned quiet_cycles;
    int unsigned cmd_tally [4];
    int          send_idle_pct;
    int          stall_pct;

    cartridge_bank_mapper_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void restore_power_on();
        int k;
        cfg_shadow   = {32'h0, 32'h0, 15'd16384, 24'd32768, 32'h0000_A000, 14'd8192, 5'd16};
        rom_bank_sel = 9'd1;
        ram_bank_sel = 4'd0;
        ram_on       = 1'b0;
        for (k = 0; k < RAM_BYTES; k++) cart_ram[k] = 8'h00;
    endfunction

    // byte position in the store through pos; returns 0 when the selected bank is not backed
    function automatic logic ram_slot(input logic [63:0] rel, output logic [63:0] pos);
        logic [63:0] bsz;
        logic [63:0] banks;
        bsz   = 64'(cfg_shadow.ram_bank_len);
        banks = 64'(cfg_shadow.ram_bank_count);
        if (banks > 64'd16) banks = 64'd16;
        pos = 64'(ram_bank_sel) * bsz + rel;
        return (pos < banks * bsz) && (pos < 64'(RAM_BYTES));
    endfunction

    function automatic t_rsp map_access(input t_req r);
        t_rsp        res;
        logic [63:0] addr;
        logic [63:0] base;
        logic [63:0] rel;
        logic [63:0] bsz;
        logic [63:0] off;
        logic [63:0] pos;
        logic        hit;
        res  = '0;
        addr = 64'(r.bus_address);
        case (r.cmd)
            CMD_ROM_RD: begin
                base = 64'(cfg_shadow.rom_window_first);
                bsz  = 64'(cfg_shadow.rom_bank_len);
                rel  = addr - base;
                if (addr < base || rel >= (bsz << 1)) begin
                    res.status    = 1'b1;
                    res.read_byte = FF_BYTE;
                end else begin
                    off = rel;
                    // upper half of the window follows the selected bank
                    if (rel >= bsz) off = 64'(rom_bank_sel) * bsz + (rel - bsz);
                    if (off < 64'(cfg_shadow.rom_image_size) && off < OFFSET_CAP) begin
                        res.rom_fetch  = 1'b1;
                        res.rom_offset = off[22:0];
                    end else begin
                        res.read_byte = FF_BYTE;
                    end
                end
            end
            CMD_CTRL_WR: begin
                base = 64'(cfg_shadow.ctl_first);
                rel  = addr - base;
                if (addr < base || rel >= CTRL_WINDOW) res.status = 1'b1;
                else if (rel < EN_LIMIT) ram_on = (r.write_byte[3:0] == ENABLE_KEY);
                else if (rel < LOW_LIMIT) rom_bank_sel[7:0] = r.write_byte;
                else if (rel < HIGH_LIMIT) rom_bank_sel[8] = r.write_byte[0];
                else ram_bank_sel = r.write_byte[3:0];
            end
            default: begin
                base = 64'(cfg_shadow.ram_window_first);
                bsz  = 64'(cfg_shadow.ram_bank_len);
                rel  = addr - base;
                hit  = (addr >= base) && (rel < bsz);
                if (!hit) res.status = 1'b1;
                if (r.cmd == CMD_RAM_RD) begin
                    res.read_byte = FF_BYTE;
                    if (hit && ram_on && ram_slot(rel, pos)) res.read_byte = cart_ram[pos[16:0]];
                end else if (hit && ram_on && ram_slot(rel, pos)) begin
                    cart_ram[pos[16:0]] = r.write_byte;
                end
            end
        endcase
        return res;
    endfunction

    function automatic t_dir_row directed_row(input int k);
        t_dir_row row;
        case (k)
            // fixed bank, then the last byte of bank one
            0:  row = {CMD_ROM_RD,  32'h0000_0000, 8'h00, TYPED, 1'b0, 8'h00, 1'b1, 23'd0};
            1:  row = {CMD_ROM_RD,  32'h0000_7FFF, 8'hFF, TYPED, 1'b0, 8'h00, 1'b1, 23'd32767};
            2:  row = {CMD_ROM_RD,  32'h0000_8000, 8'h00, TYPED, 1'b1, 8'hFF, 1'b0, 23'd0};
            3:  row = {CMD_ROM_RD,  32'hFFFF_FFFF, 8'hFF, TYPED, 1'b1, 8'hFF, 1'b0, 23'd0};
            // ram still disabled: read fill, write dropped
            4:  row = {CMD_RAM_RD,  32'h0000_A000, 8'h00, TYPED, 1'b0, 8'hFF, 1'b0, 23'd0};
            5:  row = {CMD_RAM_WR,  32'h0000_A000, 8'h55, TYPED, 1'b0, 8'h00, 1'b0, 23'd0};
            6:  row = {CMD_CTRL_WR, 32'h0000_0000, 8'h0A, TYPED, 1'b0, 8'h00, 1'b0, 23'd0};
            7:  row = {CMD_RAM_RD,  32'h0000_A000, 8'h00, TYPED, 1'b0, 8'h00, 1'b0, 23'd0};
            8:  row = {CMD_RAM_WR,  32'h0000_BFFF, 8'hFF, PREDICTED, 33'd0};
            9:  row = {CMD_RAM_RD,  32'h0000_BFFF, 8'h00, PREDICTED, 33'd0};
            10: row = {CMD_RAM_RD,  32'h0000_C000, 8'h00, TYPED, 1'b1, 8'hFF, 1'b0, 23'd0};
            11: row = {CMD_RAM_WR,  32'h0000_9FFF, 8'hAA, TYPED, 1'b1, 8'h00, 1'b0, 23'd0};
            12: row = {CMD_CTRL_WR, 32'h0000_2000, 8'hFF, PREDICTED, 33'd0};
            13: row = {CMD_CTRL_WR, 32'h0000_3000, 8'h01, PREDICTED, 33'd0};
            // bank 0x1ff lies far past the image
            14: row = {CMD_ROM_RD,  32'h0000_4000, 8'h00, TYPED, 1'b0, 8'hFF, 1'b0, 23'd0};
            15: row = {CMD_CTRL_WR, 32'h0000_2FFF, 8'h00, PREDICTED, 33'd0};
            16: row = {CMD_CTRL_WR, 32'h0000_3FFF, 8'hFE, PREDICTED, 33'd0};
            17: row = {CMD_ROM_RD,  32'h0000_4000, 8'h00, PREDICTED, 33'd0};
            18: row = {CMD_CTRL_WR, 32'h0000_4000, 8'hFF, PREDICTED, 33'd0};
            19: row = {CMD_RAM_WR,  32'h0000_A123, 8'hA5, PREDICTED, 33'd0};
            20: row = {CMD_RAM_RD,  32'h0000_A123, 8'h00, PREDICTED, 33'd0};
            21: row = {CMD_CTRL_WR, 32'h0000_5FFF, 8'h30, PREDICTED, 33'd0};
            22: row = {CMD_RAM_RD,  32'h0000_A123, 8'h00, PREDICTED, 33'd0};
            23: row = {CMD_CTRL_WR, 32'h0000_1FFF, 8'h0B, PREDICTED, 33'd0};
            default: row = {CMD_CTRL_WR, 32'h0000_6000, 8'h0A, TYPED, 1'b1, 8'h00, 1'b0, 23'd0};
        endcase
        return row;
    endfunction

    function automatic t_cfg phase_settings(input int p);
        t_cfg c;
        case (p)
            // full-size image, every bank fetchable
            0: c = {32'h0, 32'h0, 15'd16384, 24'd8388608, 32'h0000_A000, 14'd8192, 5'd16};
            // windows running off the top, one-byte image, bank count clamped
            1: c = {32'hFFFF_A000, 32'hFFFF_C000, 15'd16384, 24'd1, 32'hFFFF_F000, 14'd8192,
                    5'd31};
            2: c = {$urandom, $urandom, 15'd1, 24'd3, $urandom, 14'd1, 5'd0};
            // empty rom and ram windows
            3: c = {32'h0000_4000, 32'h0, 15'd0, 24'd32768, 32'h0000_A000, 14'd0, 5'd5};
            4: c = {32'h0000_2000, 32'h1000_0000, 15'd4096, 24'd100000, 32'h0000_A000, 14'd4096,
                    5'd3};
            6: c = {32'h0, 32'h0, 15'd16384, 24'd32768, 32'h0000_A000, 14'd8192, 5'd16};
            default: begin
                c.ctl_first        = $urandom;
                c.rom_window_first = $urandom;
                c.rom_bank_len     = 15'($urandom_range(1, 16384));
                c.rom_image_size   = 24'($urandom_range(1, 8388608));
                c.ram_window_first = $urandom;
                c.ram_bank_len     = 14'($urandom_range(1, 8192));
                c.ram_bank_count   = 5'($urandom_range(0, 16));
            end
        endcase
        return c;
    endfunction

    // mostly inside the window, some at its edges, a little anywhere
    function automatic logic [31:0] pick_address(input logic [63:0] first,
                                                 input logic [63:0] span);
        logic [63:0] a;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (span == 64'd0 || roll < 8) begin
            a = 64'($urandom);
        end else if (roll < 18) begin
            case ($urandom_range(0, 3))
                0: a = first - 64'd1;
                1: a = first;
                2: a = first + span - 64'd1;
                default: a = first + span;
            endcase
        end else if (roll < 55) begin
            a = first + 64'($urandom_range(0, (span > 64'd16) ? 15 : 32'(span) - 1));
        end else begin
            a = first + (64'($urandom) % span);
        end
        return a[31:0];
    endfunction

    function automatic t_req make_request();
        t_req        r;
        int unsigned roll;
        roll         = $urandom_range(0, 99);
        r.write_byte = 8'($urandom_range(0, 255));
        if (roll < 25) begin
            r.cmd         = CMD_ROM_RD;
            r.bus_address = pick_address(64'(cfg_shadow.rom_window_first),
                                         64'(cfg_shadow.rom_bank_len) << 1);
        end else if (roll < 45) begin
            r.cmd         = CMD_CTRL_WR;
            r.bus_address = pick_address(64'(cfg_shadow.ctl_first), CTRL_WINDOW);
            // keep ram enabled most of the time
            if ($urandom_range(0, 99) < 60) r.write_byte[3:0] = ENABLE_KEY;
        end else begin
            r.cmd         = (roll < 70) ? CMD_RAM_RD : CMD_RAM_WR;
            r.bus_address = pick_address(64'(cfg_shadow.ram_window_first),
                                         64'(cfg_shadow.ram_bank_len));
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] result %0d: %s", $time, results_seen, what);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic program_settings(input t_cfg c);
        write_reg(CFG_CTL_FIRST, c.ctl_first);
        write_reg(CFG_ROM_WINDOW_FIRST, c.rom_window_first);
        write_reg(CFG_ROM_BANK_LEN, 32'(c.rom_bank_len));
        write_reg(CFG_ROM_IMAGE_SIZE, 32'(c.rom_image_size));
        write_reg(CFG_RAM_WINDOW_FIRST, c.ram_window_first);
        write_reg(CFG_RAM_BANK_LEN, 32'(c.ram_bank_len));
        write_reg(CFG_RAM_BANK_COUNT, 32'(c.ram_bank_count));
        i_cfg_we   <= 1'b0;
        cfg_shadow = c;
    endtask

    task automatic issue_request(input t_req r, input logic typed_exp, input t_rsp typed_rsp);
        t_rsp want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (!o_in_ready);
        want = map_access(r);
        if (typed_exp) want = typed_rsp;
        due_responses.insert(due_responses.size(), want);
        cmd_tally[r.cmd]++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (due_responses.size() == 0) begin
                note_mismatch("result with no request outstanding");
            end else begin
                want = due_responses.pop_front();
                if (o_out_rsp.status !== want.status)
                    note_mismatch($sformatf("status: got %0b, expected %0b",
                                            o_out_rsp.status, want.status));
                if (o_out_rsp.read_byte !== want.read_byte)
                    note_mismatch($sformatf("read_byte: got %02h, expected %02h",
                                            o_out_rsp.read_byte, want.read_byte));
                if (o_out_rsp.rom_fetch !== want.rom_fetch)
                    note_mismatch($sformatf("rom_fetch: got %0b, expected %0b",
                                            o_out_rsp.rom_fetch, want.rom_fetch));
                if (o_out_rsp.rom_offset !== want.rom_offset)
                    note_mismatch($sformatf("rom_offset: got %06h, expected %06h",
                                            o_out_rsp.rom_offset, want.rom_offset));
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // covers the ram clearing pass after reset several times over
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: %0d cycles with no request or result moving", STALL_LIMIT);
                $display("cartridge_bank_mapper_top: mismatch");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_dir_row   row;
        t_idle_mode mode;
        restore_power_on();
        mismatch_count = 0;
        results_seen   = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_req    <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_CTL_FIRST;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            row = directed_row(k);
            issue_request(row.req, row.typed_exp, row.rsp);
        end

        for (int p = 0; p < PHASES; p++) begin
            i_in_valid <= 1'b0;
            while (due_responses.size() != 0) @(posedge i_clk);
            program_settings(phase_settings(p));
            mode = t_idle_mode'(p % 4);
            case (mode)
                IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
                IDLE_SENDER:   begin send_idle_pct = 52; stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 52; end
                default:       begin send_idle_pct = 20; stall_pct = 20; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) issue_request(make_request(), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (due_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests: %0d rom reads, %0d control writes, %0d ram reads, %0d ram writes",
                 results_seen, cmd_tally[CMD_ROM_RD], cmd_tally[CMD_CTRL_WR],
                 cmd_tally[CMD_RAM_RD], cmd_tally[CMD_RAM_WR]);
        $display("%0d register settings incl. empty and one-byte banks and top-of-space windows",
                 PHASES + 1);
        if (mismatch_count == 0) begin
            $display("cartridge_bank_mapper_top: match");
        end else begin
            $display("cartridge_bank_mapper_top: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/cbm_pkg.sv
rtl/cbm_front.sv
rtl/cbm_queue.sv
rtl/cbm_back.sv
rtl/cartridge_bank_mapper_top.sv
tb/tb_cartridge_bank_mapper_top.sv
